// ===== rtl/core/gsa_pkg.sv =====
// Shared types and constants for the generational slot allocator.
package gsa_pkg;

  // Table geometry and field widths
  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = SLOT_W + 1;
  localparam int unsigned GEN_W      = 16;
  localparam int unsigned STORE_W    = 16;

  localparam logic [GEN_W-1:0] GEN_MAX   = '1;
  localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);
  localparam logic [STORE_W-1:0] STORE_ID_RESET = STORE_W'(1);

  // Request kinds
  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_FREE    = 2'd1,
    FN_RESOLVE = 2'd2
  } func_e;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_EVAL  = 2'd2,
    S_RESP  = 2'd3
  } state_e;

  // One slot: live bit and generation
  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
  } slot_entry_t;

  // Slot memory access
  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       wdata;
  } ram_req_t;

endpackage

// ===== rtl/core/gsa_gen_ram.sv =====
// Single-port slot memory (live bit and generation) with registered read data.
module gsa_gen_ram (
  input  logic                   clk_i,
  input  gsa_pkg::ram_req_t      req_i,
  output gsa_pkg::slot_entry_t   rdata_o
);

  gsa_pkg::slot_entry_t mem [gsa_pkg::SLOT_COUNT];
  gsa_pkg::slot_entry_t rdata_q;

  // One access per cycle: write or read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/generational_slot_allocator_unit.sv =====
// Generational slot allocator: handle table with a live bit and generation per slot.
// Free, resolve and unknown kinds: IDLE latches, FETCH reads, EVAL checks, RESP loads the
// output register; the next transaction is taken only back in IDLE. Allocate: FETCH and
// EVAL repeat for every slot skipped between the search hint and the slot taken
// (single-port slot memory: read, then check). Reset clears counters and store_id (to 1);
// slot memory is not cleared: only slots below the high-water mark are used.
module generational_slot_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: store_id
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // handle_slot[7:0], handle_generation[23:8], handle_store[39:24]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  // Response stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // granted_slot[7:0], granted_generation[23:8]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned SW = gsa_pkg::SLOT_W;
  localparam int unsigned CW = gsa_pkg::CNT_W;
  localparam int unsigned GW = gsa_pkg::GEN_W;
  localparam logic [CW-1:0] SLOTS = CW'(gsa_pkg::SLOT_COUNT);

  gsa_pkg::state_e state_q, state_d;

  // Configuration register
  logic [gsa_pkg::STORE_W-1:0] store_id_q;

  // Table counters
  logic [CW-1:0] hw_q;
  logic [CW-1:0] hint_q;

  // Latched request
  logic [1:0]                  func_q;
  logic [GW-1:0]               hgen_q;
  logic [gsa_pkg::STORE_W-1:0] hstore_q;
  logic [CW-1:0]               idx_q;

  // Pending result
  gsa_pkg::status_e res_status_q;
  logic [SW-1:0]    res_slot_q;
  logic [GW-1:0]    res_gen_q;

  // Output register
  logic          m_valid_q;
  logic [1:0]    m_status_q;
  logic [SW-1:0] m_slot_q;
  logic [GW-1:0] m_gen_q;

  // Memory
  gsa_pkg::ram_req_t    ram_req;
  gsa_pkg::slot_entry_t ram_rdata;

  gsa_gen_ram u_gen_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(ram_rdata)
  );

  // Evaluation of the fetched slot
  logic in_range;
  logic slot_free;
  logic handle_ok;
  logic is_alloc, is_free, is_resolve;
  logic alloc_take, alloc_append, alloc_full, alloc_next;
  logic free_ok;
  logic s_fire, out_load;

  always_comb begin
    is_alloc   = (func_q == gsa_pkg::FN_ALLOC);
    is_free    = (func_q == gsa_pkg::FN_FREE);
    is_resolve = (func_q == gsa_pkg::FN_RESOLVE);
    in_range   = (idx_q < hw_q);
    slot_free  = !ram_rdata.live && (ram_rdata.gen != gsa_pkg::GEN_MAX);
    handle_ok  = (hstore_q == store_id_q) && in_range && ram_rdata.live
                 && (ram_rdata.gen == hgen_q);
    alloc_take   = is_alloc && in_range && slot_free;
    alloc_next   = is_alloc && in_range && !slot_free;
    alloc_append = is_alloc && !in_range && (hw_q < SLOTS);
    alloc_full   = is_alloc && !in_range && (hw_q >= SLOTS);
    free_ok      = is_free && handle_ok;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gsa_pkg::S_IDLE: begin
        if (s_axis_tvalid) state_d = gsa_pkg::S_FETCH;
      end
      gsa_pkg::S_FETCH: state_d = gsa_pkg::S_EVAL;
      gsa_pkg::S_EVAL: begin
        if (alloc_next) state_d = gsa_pkg::S_FETCH;
        else            state_d = gsa_pkg::S_RESP;
      end
      gsa_pkg::S_RESP: begin
        if (!m_valid_q || m_axis_tready) state_d = gsa_pkg::S_IDLE;
      end
      default: state_d = gsa_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    ram_req       = '0;
    case (state_q)
      gsa_pkg::S_IDLE: s_axis_tready = 1'b1;
      gsa_pkg::S_FETCH: begin
        ram_req.re   = 1'b1;
        ram_req.addr = idx_q[SW-1:0];
      end
      gsa_pkg::S_EVAL: begin
        if (alloc_take) begin
          ram_req.we         = 1'b1;
          ram_req.addr       = idx_q[SW-1:0];
          ram_req.wdata.live = 1'b1;
          ram_req.wdata.gen  = ram_rdata.gen;
        end else if (alloc_append) begin
          ram_req.we         = 1'b1;
          ram_req.addr       = hw_q[SW-1:0];
          ram_req.wdata.live = 1'b1;
          ram_req.wdata.gen  = gsa_pkg::GEN_FIRST;
        end else if (free_ok) begin
          // a saturated generation stays put: slot retired
          ram_req.we         = 1'b1;
          ram_req.addr       = idx_q[SW-1:0];
          ram_req.wdata.live = 1'b0;
          ram_req.wdata.gen  = (ram_rdata.gen == gsa_pkg::GEN_MAX) ? gsa_pkg::GEN_MAX
                                                                   : ram_rdata.gen + GW'(1);
        end
      end
      gsa_pkg::S_RESP: out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gsa_pkg::S_IDLE;
      store_id_q <= gsa_pkg::STORE_ID_RESET;
      hw_q       <= '0;
      hint_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) store_id_q <= cfg_wdata_i;
      // table updates at evaluation
      if (state_q == gsa_pkg::S_EVAL) begin
        if (alloc_take) begin
          hint_q <= idx_q + CW'(1);
        end else if (alloc_append) begin
          hw_q   <= hw_q + CW'(1);
          hint_q <= hw_q + CW'(1);
        end else if (free_ok) begin
          if (idx_q < hint_q) hint_q <= idx_q;
        end
      end
      // output register handshake
      if (out_load)           m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // Request latch, scan index and result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      func_q   <= s_axis_tuser;
      hgen_q   <= s_axis_tdata[8 +: GW];
      hstore_q <= s_axis_tdata[8 + GW +: gsa_pkg::STORE_W];
      if (s_axis_tuser == gsa_pkg::FN_ALLOC) idx_q <= hint_q;
      else                                   idx_q <= {1'b0, s_axis_tdata[SW-1:0]};
    end else if ((state_q == gsa_pkg::S_EVAL) && alloc_next) begin
      idx_q <= idx_q + CW'(1);
    end
    if (state_q == gsa_pkg::S_EVAL) begin
      res_slot_q   <= '0;
      res_gen_q    <= '0;
      res_status_q <= gsa_pkg::ST_BAD;
      if (alloc_take) begin
        res_status_q <= gsa_pkg::ST_OK;
        res_slot_q   <= idx_q[SW-1:0];
        res_gen_q    <= ram_rdata.gen;
      end else if (alloc_append) begin
        res_status_q <= gsa_pkg::ST_OK;
        res_slot_q   <= hw_q[SW-1:0];
        res_gen_q    <= gsa_pkg::GEN_FIRST;
      end else if (alloc_full) begin
        res_status_q <= gsa_pkg::ST_FULL;
      end else if ((is_free || is_resolve) && handle_ok) begin
        res_status_q <= gsa_pkg::ST_OK;
      end
    end
    if (out_load) begin
      m_status_q <= res_status_q;
      m_slot_q   <= res_slot_q;
      m_gen_q    <= res_gen_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {m_gen_q, m_slot_q};

endmodule

// ===== tb/sv/slot_allocator_checker.sv =====
// Checker for the slot allocator: shadows the handle table, predicts and compares responses.
module slot_allocator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // handle_slot[7:0], handle_generation[23:8], handle_store[39:24]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // granted_slot[7:0], granted_generation[23:8]
  input  logic [1:0]  m_axis_tuser,  // status[1:0]
  output int          errors_o,
  output int          outstanding_o,
  output int          requests_o,
  output int          grants_o,
  output int          full_o,
  output int          rejects_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsa_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [GEN_W-1:0]   generation;
  } response_t;

  // Shadow copy of the handle table
  logic               slot_live [SLOT_COUNT];
  logic [GEN_W-1:0]   slot_gen  [SLOT_COUNT];
  logic [CNT_W-1:0]   fill_mark = '0;
  logic [CNT_W-1:0]   scan_from = '0;
  logic [STORE_W-1:0] table_id  = STORE_ID_RESET;

  response_t          expected_grants_q[$];
  response_t          want;

  initial begin
    errors_o      = 0;
    outstanding_o = 0;
    requests_o    = 0;
    grants_o      = 0;
    full_o        = 0;
    rejects_o     = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    errors_o++;
    $display("%0t ns: %s: expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  // Handle check: right table, slot appended, slot live, generation matches
  function automatic bit handle_resolves(logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen,
                                         logic [STORE_W-1:0] store);
    return (store == table_id) && (CNT_W'(slot) < fill_mark) && slot_live[slot] &&
           (slot_gen[slot] == gen);
  endfunction

  // Applies one request to the shadow table and returns the response it must produce
  function automatic response_t serve_request(logic [1:0] func, logic [SLOT_W-1:0] slot,
                                              logic [GEN_W-1:0] gen, logic [STORE_W-1:0] store);
    response_t rsp;
    int        idx;
    bit        found;
    rsp.status     = ST_BAD;
    rsp.slot       = '0;
    rsp.generation = '0;
    found = 1'b0;
    idx   = 0;
    case (func)
      FN_ALLOC: begin
        // first dead, non-retired slot from the hint up
        for (int i = int'(scan_from); i < int'(fill_mark); i++) begin
          if (!found && !slot_live[i] && slot_gen[i] != GEN_MAX) begin
            found = 1'b1;
            idx   = i;
          end
        end
        // otherwise append a fresh slot
        if (!found && fill_mark < CNT_W'(SLOT_COUNT)) begin
          idx           = int'(fill_mark);
          slot_gen[idx] = GEN_FIRST;
          fill_mark     = fill_mark + 1'b1;
          found         = 1'b1;
        end
        if (found) begin
          slot_live[idx] = 1'b1;
          scan_from      = CNT_W'(idx + 1);
          rsp.status     = ST_OK;
          rsp.slot       = SLOT_W'(idx);
          rsp.generation = slot_gen[idx];
        end else begin
          rsp.status = ST_FULL;
        end
      end
      FN_FREE: begin
        if (handle_resolves(slot, gen, store)) begin
          if (CNT_W'(slot) < scan_from) scan_from = CNT_W'(slot);
          slot_live[slot] = 1'b0;
          // a saturated generation stays put: slot retired
          if (slot_gen[slot] != GEN_MAX) slot_gen[slot] = slot_gen[slot] + 1'b1;
          rsp.status = ST_OK;
        end
      end
      FN_RESOLVE: begin
        if (handle_resolves(slot, gen, store)) rsp.status = ST_OK;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < SLOT_COUNT; n++) begin
        slot_live[n] = 1'b0;
        slot_gen[n]  = '0;
      end
      fill_mark = '0;
      scan_from = '0;
      table_id  = STORE_ID_RESET;
      expected_grants_q.delete();
      outstanding_o <= 0;
    end else begin
      // compare the response transaction against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_grants_q.size() == 0) begin
          report_mismatch("response with nothing pending", '0, {6'b0, m_axis_tuser, m_axis_tdata});
        end else begin
          want = expected_grants_q.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch("status", want.status, m_axis_tuser);
          if (m_axis_tdata[7:0] !== want.slot)
            report_mismatch("granted slot", want.slot, m_axis_tdata[7:0]);
          if (m_axis_tdata[23:8] !== want.generation)
            report_mismatch("granted generation", want.generation, m_axis_tdata[23:8]);
        end
      end
      if (cfg_we_i) table_id = cfg_wdata_i;
      // predict for each request transaction
      if (s_axis_tvalid && s_axis_tready) begin
        want = serve_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8],
                             s_axis_tdata[39:24]);
        expected_grants_q = {expected_grants_q, want};
        requests_o++;
        case (want.status)
          ST_OK:   if (s_axis_tuser == FN_ALLOC) grants_o++;
          ST_FULL: full_o++;
          default: rejects_o++;
        endcase
      end
      outstanding_o <= expected_grants_q.size();
    end
  end

endmodule

// ===== tb/sv/generational_slot_allocator_unit_tb.sv =====
// Testbench top: request stimulus, response back-pressure and verdict for the slot allocator.
module generational_slot_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsa_pkg::*;

  localparam logic [1:0] FN_UNDEFINED   = 2'd3;
  localparam int         RANDOM_PHASES  = 6;
  localparam int         PHASE_ITEMS    = 250;
  localparam int         LONG_HOLD      = 400;
  localparam int         DRAIN_CYCLES   = 600;
  localparam int         TIMEOUT_CYCLES = 12_000_000;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  generation;
  } handle_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [15:0]  cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata  = '0;  // handle_slot[7:0], handle_generation[23:8], handle_store[39:24]
  logic [1:0]   s_axis_tuser  = '0;  // func[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;        // granted_slot[7:0], granted_generation[23:8]
  logic [1:0]   m_axis_tuser;        // status[1:0]

  int           mismatches;
  int           outstanding;
  int           requests;
  int           grants;
  int           full_hits;
  int           rejects;

  // stimulus bookkeeping: handles known live, handles already freed
  handle_t            live_handles[$];
  handle_t            dead_handles[$];
  logic [1:0]         sent_kinds[$];
  logic [1:0]         pending_kind;
  logic [STORE_W-1:0] store_now    = STORE_ID_RESET;
  bit                 track_grants = 1'b0;
  bit                 rx_steady    = 1'b1;
  bit                 hold_off_req = 1'b0;

  generational_slot_allocator_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  slot_allocator_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(mismatches), .outstanding_o(outstanding), .requests_o(requests),
    .grants_o(grants), .full_o(full_hits), .rejects_o(rejects)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("timeout with %0d responses outstanding", outstanding);
    $display("generational_slot_allocator_unit_tb: errors");
    $finish;
  end

  // Collect granted handles so later frees and resolves can use them
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready && sent_kinds.size() != 0) begin
      pending_kind = sent_kinds.pop_front();
      if (track_grants && pending_kind == FN_ALLOC && m_axis_tuser == ST_OK)
        live_handles = {live_handles, handle_t'({m_axis_tdata[7:0], m_axis_tdata[23:8]})};
    end
    if (s_axis_tvalid && s_axis_tready) sent_kinds = {sent_kinds, s_axis_tuser};
  end

  // Response side: run/stall pattern, steady stretches, one long hold-off on request
  initial begin
    int run;
    int stall;
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
        m_axis_tready <= 1'b1;
        repeat (run) @(posedge clk_i);
        stall = $urandom_range(0, 6);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // One request transaction; valid stays up for a back-to-back follower
  task automatic offer(logic [1:0] kind, logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen,
                       logic [STORE_W-1:0] store);
    int k;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {store, gen, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // a free of a known live handle retires it from the pool
    if (kind == FN_FREE && store == store_now) begin
      for (k = live_handles.size() - 1; k >= 0; k--) begin
        if (live_handles[k].slot == slot && live_handles[k].generation == gen) begin
          live_handles.delete(k);
          dead_handles = {dead_handles, handle_t'({slot, gen})};
          if (dead_handles.size() > 64) void'(dead_handles.pop_front());
        end
      end
    end
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every response to come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic probe(logic [1:0] kind, logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen,
                       logic [STORE_W-1:0] store);
    offer(kind, slot, gen, store);
    drain();
  endtask

  task automatic write_store_id(logic [STORE_W-1:0] id);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    store_now = id;
  endtask

  // Mostly well-formed traffic on known handles, some damaged or stale, a little noise
  task automatic offer_random(int alloc_pct, int free_pct);
    int                 pick;
    handle_t            h;
    logic [1:0]         kind;
    logic [SLOT_W-1:0]  slot;
    logic [GEN_W-1:0]   gen;
    logic [STORE_W-1:0] store;
    pick  = $urandom_range(0, 99);
    kind  = FN_ALLOC;
    slot  = SLOT_W'($urandom);
    gen   = GEN_W'($urandom);
    store = STORE_W'($urandom);
    if (pick < 6) begin
      kind = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) store = store_now;
    end else if (pick >= 6 + alloc_pct && live_handles.size() != 0) begin
      h     = live_handles[$urandom_range(0, live_handles.size() - 1)];
      slot  = h.slot;
      gen   = h.generation;
      store = store_now;
      if (pick < 6 + alloc_pct + free_pct) begin
        kind = FN_FREE;
      end else begin
        kind = ($urandom_range(0, 1) == 1) ? FN_FREE : FN_RESOLVE;
        case ($urandom_range(0, 4))
          0: kind = FN_RESOLVE;
          1: slot = slot ^ SLOT_W'(1 << $urandom_range(0, SLOT_W - 1));
          2: gen = gen ^ GEN_W'(1 << $urandom_range(0, GEN_W - 1));
          3: store = store ^ STORE_W'(1 << $urandom_range(0, STORE_W - 1));
          default: begin
            if (dead_handles.size() != 0) begin
              h    = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
              slot = h.slot;
              gen  = h.generation;
            end else begin
              gen = gen + 1'b1;
            end
          end
        endcase
      end
    end
    offer(kind, slot, gen, store);
  endtask

  initial begin
    int                 phase;
    int                 budget;
    int                 burst;
    int                 k;
    int                 alloc_pct;
    int                 free_pct;
    logic [STORE_W-1:0] phase_store;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    track_grants = 1'b1;
    rx_steady    = 1'b0;

    // Directed checks, one transaction at a time
    probe(FN_ALLOC, '1, '1, '1);                    // fresh table: slot 0 appended
    probe(FN_ALLOC, '0, '0, '0);                    // slot 1 appended
    probe(FN_RESOLVE, 8'd1, 16'd1, store_now);
    probe(FN_RESOLVE, 8'd1, 16'd1, store_now ^ 16'h8000);
    probe(FN_RESOLVE, 8'd1, 16'd0, store_now);
    probe(FN_RESOLVE, 8'd200, 16'd1, store_now);    // beyond the high-water mark
    probe(FN_RESOLVE, 8'd0, GEN_MAX, store_now);    // live slot, wrong generation
    probe(FN_FREE, 8'd0, GEN_MAX, store_now);
    probe(FN_UNDEFINED, '1, '1, '1);
    probe(FN_UNDEFINED, 8'd1, 16'd1, store_now);    // valid handle, unknown kind
    probe(FN_FREE, 8'd1, 16'd1, store_now);
    probe(FN_FREE, 8'd1, 16'd1, store_now);         // double free
    probe(FN_RESOLVE, 8'd1, 16'd2, store_now);
    probe(FN_ALLOC, '0, '0, '0);                    // reuse slot 1 at generation 2
    probe(FN_ALLOC, 8'h55, 16'hAAAA, 16'h5555);
    probe(FN_FREE, '0, '0, '0);
    probe(FN_FREE, '1, '1, '1);
    probe(FN_RESOLVE, 8'd2, 16'd1, store_now);
    probe(FN_FREE, 8'd2, 16'd1, store_now);         // hint drops back to slot 2
    probe(FN_ALLOC, '1, '1, '1);
    probe(FN_RESOLVE, 8'd2, 16'd2, store_now);

    // Random phases: fill to table-full, drain, refill, each under its own store id
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       begin phase_store = '1;                  alloc_pct = 50; free_pct = 15; end
        1:       begin phase_store = '0;                  alloc_pct = 68; free_pct = 6;  end
        2:       begin phase_store = STORE_W'($urandom);  alloc_pct = 20; free_pct = 50; end
        3:       begin phase_store = 16'h8000;            alloc_pct = 40; free_pct = 30; end
        4:       begin phase_store = STORE_W'($urandom);  alloc_pct = 60; free_pct = 12; end
        default: begin phase_store = STORE_ID_RESET;      alloc_pct = 25; free_pct = 45; end
      endcase
      write_store_id(phase_store);
      if (phase == 1) hold_off_req = 1'b1;
      budget = PHASE_ITEMS;
      while (budget > 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (k = 0; k < burst && budget > 0; k++) begin
          offer_random(alloc_pct, free_pct);
          budget--;
        end
        pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests checked: %0d grants, %0d table-full, %0d rejected handles",
             requests, grants, full_hits, rejects);
    $display("covered append and reuse, stale and damaged handles, store ids 0/1/0xFFFF "
             , "and others, long output hold-off");
    if (mismatches == 0 && outstanding == 0) begin
      $display("generational_slot_allocator_unit_tb: clean");
    end else begin
      $display("generational_slot_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gsa_pkg.sv
rtl/core/gsa_gen_ram.sv
rtl/core/generational_slot_allocator_unit.sv
tb/sv/slot_allocator_checker.sv
tb/sv/generational_slot_allocator_unit_tb.sv
